>>> src/nmea_rmc_position_parser_macros.svh
// Assertion helpers for the NMEA RMC position parser checker.
`ifndef NMEA_RMC_POSITION_PARSER_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define NRPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nrpp checker: implication failed");

// Next-cycle implication, muted while reset is held.
`define NRPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nrpp checker: next-cycle implication failed");

// Next-cycle implication that is live during reset as well.
`define NRPP_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nrpp checker: reset behaviour failed");

`endif

>>> src/nrpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nrpp_pkg;

    // Number format limits
    localparam int COORD_INT_DIGITS  = 5;
    localparam int COORD_FRAC_DIGITS = 5;
    localparam int TIME_INT_DIGITS   = 6;
    localparam int TIME_FRAC_DIGITS  = 3;

    // Field and working widths
    localparam int IN_W        = 8;
    localparam int UTC_W       = 30;
    localparam int COORD_W     = 35;
    localparam int OUT_TDATA_W = ((UTC_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int INT_ACC_W   = 20;
    localparam int FRAC_ACC_W  = 17;
    localparam int CNT_W       = 3;
    localparam int CINT_W      = 17;   // up to five integer digits
    localparam int DEG_W       = 10;
    localparam int MM_W        = 7;
    localparam int FSC_W       = 17;
    localparam int X_W         = 30;
    localparam int Q_W         = 24;
    localparam int E7_W        = 34;

    typedef logic [IN_W-1:0]       t_byte;
    typedef logic [UTC_W-1:0]      t_utc;
    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [INT_ACC_W-1:0]  t_acc_int;
    typedef logic [FRAC_ACC_W-1:0] t_acc_frac;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CINT_W-1:0]     t_cint;
    typedef logic [DEG_W-1:0]      t_deg;
    typedef logic [MM_W-1:0]       t_mm;
    typedef logic [FSC_W-1:0]      t_fsc;
    typedef logic [X_W-1:0]        t_x;
    typedef logic [Q_W-1:0]        t_q;
    typedef logic [E7_W-1:0]       t_e7;

    // Parser phase
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_P       = 4'd1,
        PH_R       = 4'd2,
        PH_M       = 4'd3,
        PH_C       = 4'd4,
        PH_COMMA0  = 4'd5,
        PH_TIME    = 4'd6,
        PH_A       = 4'd7,
        PH_COMMA1  = 4'd8,
        PH_LAT     = 4'd9,
        PH_LATHEMI = 4'd10,
        PH_COMMA2  = 4'd11,
        PH_LON     = 4'd12,
        PH_LONHEMI = 4'd13
    } t_phase;

    // Verdict on one byte of a number field
    typedef enum logic [1:0] {
        NUM_MORE = 2'd0,
        NUM_END  = 2'd1,
        NUM_BAD  = 2'd2
    } t_num_res;

    // Characters
    localparam t_byte CH_G     = 8'h47;
    localparam t_byte CH_P     = 8'h50;
    localparam t_byte CH_R     = 8'h52;
    localparam t_byte CH_M     = 8'h4D;
    localparam t_byte CH_C     = 8'h43;
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_S     = 8'h53;
    localparam t_byte CH_W     = 8'h57;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_POINT = 8'h2E;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;

    // Saturation point of the fraction digit count
    localparam t_cnt FRAC_CNT_MAX = 3'd7;

    // Powers of ten, 10^0 .. 10^7
    function automatic logic [23:0] pow10(input t_cnt n);
        logic [23:0] v;
        case (n)
            3'd0:    v = 24'd1;
            3'd1:    v = 24'd10;
            3'd2:    v = 24'd100;
            3'd3:    v = 24'd1000;
            3'd4:    v = 24'd10000;
            3'd5:    v = 24'd100000;
            3'd6:    v = 24'd1000000;
            default: v = 24'd10000000;
        endcase
        return v;
    endfunction

    // Scale factors of the conversion
    localparam t_utc  MS_PER_S  = 30'd1000;
    localparam t_cint DEG_DIV   = 17'd100;
    localparam t_e7   DEG_SCALE = 34'd10000000;
    // minutes * 1e7: whole minutes carry 10^F * 10^(7-F)
    localparam t_x    MM_SCALE  = 30'd10000000;
    localparam t_x    MIN_SCALE = t_x'(10 ** (7 - COORD_FRAC_DIGITS));

    // int / 100 = (int >> 2) / 25, by reciprocal 5243 / 2^17
    localparam logic [31:0] DEG_RECIP = 32'd5243;
    localparam int          DEG_SHIFT = 17;
    // x / 60 = (x >> 2) / 15, by reciprocal 0x88888889 / 2^35
    localparam logic [59:0] MIN_RECIP = 60'h0_0000_0088_8888_89;
    localparam int          MIN_SHIFT = 35;

endpackage

`default_nettype wire

>>> src/nmea_rmc_position_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// NMEA RMC position parser.
// Slave stream (i_tvalid/i_tready/i_tdata) carries one received character
// per item. The parser hunts for "GPRMC", reads the UTC time, checks ",A,",
// reads latitude and longitude with their hemisphere characters and, on the
// final hemisphere character, puts one result on the master stream
// (o_tvalid/o_tready/o_tdata): time in ms and both coordinates in signed
// 1e-7 degrees. Any unexpected character sends it back to hunting.
// Throughput: one character per cycle while i_tready is high. Each character
// is handled by the parser register; coordinate conversion runs through a
// five-register pipeline (launch, four arithmetic stages) beside it.
// A result passes from the launch register through s1 .. s4 into the output
// register, shows on o_tvalid there and is held until o_tready.
// Stall: characters keep flowing while a result waits; only the final
// hemisphere character of a following sentence is held off (i_tready low)
// while an earlier result still sits in the pipeline or output register.
// Reset (i_rst_n low, synchronous): back to hunting, pipeline and output
// emptied.
module nmea_rmc_position_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_tvalid,
    output logic        i_tready,
    input  wire  [7:0]  i_tdata,   // [7:0] rx_byte
    output logic        o_tvalid,
    input  wire         o_tready,
    output logic [nrpp_pkg::OUT_TDATA_W-1:0] o_tdata
    // o_tdata: [29:0] utc_time_ms, [64:30] latitude_e7, [99:65] longitude_e7,
    //          [103:100] zero
);

    // ---------------------------------------------------------------
    // Parser state
    nrpp_pkg::t_phase    r_phase, n_phase;
    nrpp_pkg::t_acc_int  r_int;
    nrpp_pkg::t_acc_frac r_frac;
    nrpp_pkg::t_cnt      r_int_cnt;
    nrpp_pkg::t_cnt      r_frac_cnt;
    logic                r_point;
    nrpp_pkg::t_utc      r_time_hold;
    nrpp_pkg::t_coord    r_lat_hold;

    logic                w_acc;
    nrpp_pkg::t_byte     w_b;
    logic                w_digit;
    logic [3:0]          w_d;
    nrpp_pkg::t_cnt      w_max_int;
    nrpp_pkg::t_cnt      w_max_frac;
    logic                w_in_num;
    nrpp_pkg::t_num_res  w_num_res;
    logic                w_fail;
    logic                w_clear;
    logic                w_num_step;
    logic                w_time_load;
    logic                w_launch;
    logic                w_launch_lon;
    nrpp_pkg::t_cnt      w_kept_time;
    nrpp_pkg::t_cnt      w_kept_coord;
    nrpp_pkg::t_utc      w_time_ms;
    logic                w_lon_busy;

    assign w_acc = i_tvalid && i_tready;
    assign w_b   = i_tdata;

    // Number field decode
    always_comb begin
        w_digit    = (w_b >= nrpp_pkg::CH_0) && (w_b <= nrpp_pkg::CH_9);
        w_d        = 4'(w_b - nrpp_pkg::CH_0);
        w_in_num   = (r_phase == nrpp_pkg::PH_TIME) || (r_phase == nrpp_pkg::PH_LAT) ||
                     (r_phase == nrpp_pkg::PH_LON);
        w_max_int  = (r_phase == nrpp_pkg::PH_TIME) ?
                     nrpp_pkg::t_cnt'(nrpp_pkg::TIME_INT_DIGITS) :
                     nrpp_pkg::t_cnt'(nrpp_pkg::COORD_INT_DIGITS);
        w_max_frac = (r_phase == nrpp_pkg::PH_TIME) ?
                     nrpp_pkg::t_cnt'(nrpp_pkg::TIME_FRAC_DIGITS) :
                     nrpp_pkg::t_cnt'(nrpp_pkg::COORD_FRAC_DIGITS);
        if (w_digit) begin
            w_num_res = (!r_point && (r_int_cnt >= w_max_int)) ?
                        nrpp_pkg::NUM_BAD : nrpp_pkg::NUM_MORE;
        end else if (w_b == nrpp_pkg::CH_POINT) begin
            w_num_res = r_point ? nrpp_pkg::NUM_BAD : nrpp_pkg::NUM_MORE;
        end else if (w_b == nrpp_pkg::CH_COMMA) begin
            w_num_res = ((r_int_cnt == '0) && (r_frac_cnt == '0)) ?
                        nrpp_pkg::NUM_BAD : nrpp_pkg::NUM_END;
        end else begin
            w_num_res = nrpp_pkg::NUM_BAD;
        end
    end

    // Next phase
    always_comb begin
        w_fail  = 1'b0;
        n_phase = r_phase;
        unique case (r_phase)
            nrpp_pkg::PH_HUNT: begin
                if (w_b == nrpp_pkg::CH_G) n_phase = nrpp_pkg::PH_P; else w_fail = 1'b1;
            end
            nrpp_pkg::PH_P: begin
                if (w_b == nrpp_pkg::CH_P) n_phase = nrpp_pkg::PH_R; else w_fail = 1'b1;
            end
            nrpp_pkg::PH_R: begin
                if (w_b == nrpp_pkg::CH_R) n_phase = nrpp_pkg::PH_M; else w_fail = 1'b1;
            end
            nrpp_pkg::PH_M: begin
                if (w_b == nrpp_pkg::CH_M) n_phase = nrpp_pkg::PH_C; else w_fail = 1'b1;
            end
            nrpp_pkg::PH_C: begin
                if (w_b == nrpp_pkg::CH_C) n_phase = nrpp_pkg::PH_COMMA0; else w_fail = 1'b1;
            end
            nrpp_pkg::PH_COMMA0: begin
                if (w_b == nrpp_pkg::CH_COMMA) n_phase = nrpp_pkg::PH_TIME;
                else w_fail = 1'b1;
            end
            nrpp_pkg::PH_TIME: begin
                if (w_num_res == nrpp_pkg::NUM_BAD) w_fail = 1'b1;
                else if (w_num_res == nrpp_pkg::NUM_END) n_phase = nrpp_pkg::PH_A;
            end
            nrpp_pkg::PH_A: begin
                if (w_b == nrpp_pkg::CH_A) n_phase = nrpp_pkg::PH_COMMA1; else w_fail = 1'b1;
            end
            nrpp_pkg::PH_COMMA1: begin
                if (w_b == nrpp_pkg::CH_COMMA) n_phase = nrpp_pkg::PH_LAT;
                else w_fail = 1'b1;
            end
            nrpp_pkg::PH_LAT: begin
                if (w_num_res == nrpp_pkg::NUM_BAD) w_fail = 1'b1;
                else if (w_num_res == nrpp_pkg::NUM_END) n_phase = nrpp_pkg::PH_LATHEMI;
            end
            nrpp_pkg::PH_LATHEMI: n_phase = nrpp_pkg::PH_COMMA2;
            nrpp_pkg::PH_COMMA2: begin
                if (w_b == nrpp_pkg::CH_COMMA) n_phase = nrpp_pkg::PH_LON;
                else w_fail = 1'b1;
            end
            nrpp_pkg::PH_LON: begin
                if (w_num_res == nrpp_pkg::NUM_BAD) w_fail = 1'b1;
                else if (w_num_res == nrpp_pkg::NUM_END) n_phase = nrpp_pkg::PH_LONHEMI;
            end
            nrpp_pkg::PH_LONHEMI: n_phase = nrpp_pkg::PH_HUNT;
            default: w_fail = 1'b1;
        endcase
        // a mismatching 'G' already starts the next header
        if (w_fail) begin
            n_phase = (w_b == nrpp_pkg::CH_G) ? nrpp_pkg::PH_P : nrpp_pkg::PH_HUNT;
        end
    end

    // Phase outputs: datapath controls
    always_comb begin
        w_clear      = 1'b0;
        w_num_step   = 1'b0;
        w_time_load  = 1'b0;
        w_launch     = 1'b0;
        w_launch_lon = 1'b0;
        unique case (r_phase)
            nrpp_pkg::PH_COMMA0, nrpp_pkg::PH_COMMA1, nrpp_pkg::PH_COMMA2: begin
                w_clear = (w_b == nrpp_pkg::CH_COMMA);
            end
            nrpp_pkg::PH_TIME: begin
                w_num_step  = (w_num_res == nrpp_pkg::NUM_MORE);
                w_time_load = (w_num_res == nrpp_pkg::NUM_END);
            end
            nrpp_pkg::PH_LAT, nrpp_pkg::PH_LON: begin
                w_num_step = (w_num_res == nrpp_pkg::NUM_MORE);
            end
            nrpp_pkg::PH_LATHEMI: w_launch = 1'b1;
            nrpp_pkg::PH_LONHEMI: begin
                w_launch     = 1'b1;
                w_launch_lon = 1'b1;
            end
            default: ;
        endcase
    end

    // Kept fraction digits and time in ms
    always_comb begin
        w_kept_time  = (r_frac_cnt < nrpp_pkg::t_cnt'(nrpp_pkg::TIME_FRAC_DIGITS)) ?
                       r_frac_cnt : nrpp_pkg::t_cnt'(nrpp_pkg::TIME_FRAC_DIGITS);
        w_kept_coord = (r_frac_cnt < nrpp_pkg::t_cnt'(nrpp_pkg::COORD_FRAC_DIGITS)) ?
                       r_frac_cnt : nrpp_pkg::t_cnt'(nrpp_pkg::COORD_FRAC_DIGITS);
        w_time_ms    = nrpp_pkg::t_utc'(nrpp_pkg::t_utc'(r_int) * nrpp_pkg::MS_PER_S) +
                       nrpp_pkg::t_utc'(nrpp_pkg::t_utc'(r_frac) * nrpp_pkg::t_utc'(
                           nrpp_pkg::pow10(nrpp_pkg::t_cnt'(nrpp_pkg::TIME_FRAC_DIGITS) -
                                           w_kept_time)));
    end

    w_in_num_unused_guard: assert final (1'b1);

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= nrpp_pkg::PH_HUNT;
            r_int_cnt  <= '0;
            r_frac_cnt <= '0;
            r_point    <= 1'b0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            if (w_clear) begin
                r_int_cnt  <= '0;
                r_frac_cnt <= '0;
                r_point    <= 1'b0;
            end else if (w_in_num && w_num_step) begin
                if (w_digit) begin
                    if (!r_point) begin
                        r_int_cnt <= r_int_cnt + 3'd1;
                    end else if (r_frac_cnt < nrpp_pkg::FRAC_CNT_MAX) begin
                        r_frac_cnt <= r_frac_cnt + 3'd1;
                    end
                end else begin
                    r_point <= 1'b1;
                end
            end
        end
    end

    // Accumulators and held time
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (w_clear) begin
                r_int  <= '0;
                r_frac <= '0;
            end else if (w_in_num && w_num_step && w_digit) begin
                if (!r_point) begin
                    r_int <= nrpp_pkg::t_acc_int'(r_int * 5'd10 + nrpp_pkg::t_acc_int'(w_d));
                end else if (r_frac_cnt < w_max_frac) begin
                    r_frac <= nrpp_pkg::t_acc_frac'(r_frac * 5'd10 +
                                                    nrpp_pkg::t_acc_frac'(w_d));
                end
            end
            if (w_time_load) begin
                r_time_hold <= w_time_ms;
            end
        end
    end

    // ---------------------------------------------------------------
    // Conversion pipeline: launch, s1 .. s4, then latitude hold or output
    logic                r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic                r_s0_lon, r_s1_lon, r_s2_lon, r_s3_lon, r_s4_lon;
    logic                r_s0_neg, r_s1_neg, r_s2_neg, r_s3_neg, r_s4_neg;
    nrpp_pkg::t_cint     r_s0_int, r_s1_int;
    nrpp_pkg::t_acc_frac r_s0_frac;
    nrpp_pkg::t_cnt      r_s0_shift;
    nrpp_pkg::t_deg      r_s1_deg;
    nrpp_pkg::t_fsc      r_s1_fsc, r_s2_fsc;
    nrpp_pkg::t_mm       r_s2_mm;
    nrpp_pkg::t_e7       r_s2_deg_e7, r_s3_deg_e7, r_s4_deg_e7;
    nrpp_pkg::t_x        r_s3_x;
    nrpp_pkg::t_q        r_s4_q;

    logic [31:0]         w_deg_prod;
    logic [33:0]         w_fsc_prod;
    nrpp_pkg::t_cint     w_hund;
    nrpp_pkg::t_cint     w_mm_full;
    logic [59:0]         w_min_prod;
    nrpp_pkg::t_e7       w_mag;
    nrpp_pkg::t_coord    w_coord;

    always_comb begin
        w_deg_prod = 32'(r_s0_int[nrpp_pkg::CINT_W-1:2]) * nrpp_pkg::DEG_RECIP;
        w_fsc_prod = 34'(r_s0_frac) * 34'(nrpp_pkg::pow10(r_s0_shift));
        w_hund     = nrpp_pkg::t_cint'(r_s1_deg) * nrpp_pkg::DEG_DIV;
        w_mm_full  = r_s1_int - w_hund;
        w_min_prod = 60'(r_s3_x[nrpp_pkg::X_W-1:2]) * nrpp_pkg::MIN_RECIP;
        w_mag      = r_s4_deg_e7 + nrpp_pkg::t_e7'(r_s4_q);
        w_coord    = r_s4_neg ? (nrpp_pkg::t_coord'(0) - nrpp_pkg::t_coord'(w_mag)) :
                                nrpp_pkg::t_coord'(w_mag);
    end

    // Pipeline valid and tag bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s0_vld <= w_acc && w_launch;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        // launch: capture the finished number and hemisphere
        r_s0_lon   <= w_launch_lon;
        r_s0_neg   <= (w_b == nrpp_pkg::CH_S) || (w_b == nrpp_pkg::CH_W);
        r_s0_int   <= r_int[nrpp_pkg::CINT_W-1:0];
        r_s0_frac  <= r_frac;
        r_s0_shift <= nrpp_pkg::t_cnt'(nrpp_pkg::COORD_FRAC_DIGITS) - w_kept_coord;
        // s1: whole degrees, scaled fraction
        r_s1_lon   <= r_s0_lon;
        r_s1_neg   <= r_s0_neg;
        r_s1_int   <= r_s0_int;
        r_s1_deg   <= w_deg_prod[nrpp_pkg::DEG_SHIFT +: nrpp_pkg::DEG_W];
        r_s1_fsc   <= nrpp_pkg::t_fsc'(w_fsc_prod);
        // s2: whole minutes, degrees in 1e-7
        r_s2_lon    <= r_s1_lon;
        r_s2_neg    <= r_s1_neg;
        r_s2_mm     <= w_mm_full[nrpp_pkg::MM_W-1:0];
        r_s2_fsc    <= r_s1_fsc;
        r_s2_deg_e7 <= nrpp_pkg::t_e7'(r_s1_deg) * nrpp_pkg::DEG_SCALE;
        // s3: minutes times 1e7 in raw units
        r_s3_lon    <= r_s2_lon;
        r_s3_neg    <= r_s2_neg;
        r_s3_deg_e7 <= r_s2_deg_e7;
        r_s3_x      <= nrpp_pkg::t_x'(nrpp_pkg::t_x'(r_s2_mm) * nrpp_pkg::MM_SCALE) +
                       nrpp_pkg::t_x'(nrpp_pkg::t_x'(r_s2_fsc) * nrpp_pkg::MIN_SCALE);
        // s4: divide by sixty
        r_s4_lon    <= r_s3_lon;
        r_s4_neg    <= r_s3_neg;
        r_s4_deg_e7 <= r_s3_deg_e7;
        r_s4_q      <= w_min_prod[nrpp_pkg::MIN_SHIFT +: nrpp_pkg::Q_W];
        // latitude lands in its hold register
        if (r_s4_vld && !r_s4_lon) begin
            r_lat_hold <= w_coord;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    logic             r_out_vld;
    nrpp_pkg::t_utc   r_out_time;
    nrpp_pkg::t_coord r_out_lat;
    nrpp_pkg::t_coord r_out_lon;
    logic             w_out_load;

    assign w_out_load = r_s4_vld && r_s4_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_out_load || (r_out_vld && !o_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_time <= r_time_hold;
            r_out_lat  <= r_lat_hold;
            r_out_lon  <= w_coord;
        end
    end

    // One result in flight at most: hold off the next final character
    assign w_lon_busy = (r_s0_vld && r_s0_lon) || (r_s1_vld && r_s1_lon) ||
                        (r_s2_vld && r_s2_lon) || (r_s3_vld && r_s3_lon) ||
                        (r_s4_vld && r_s4_lon) || r_out_vld;
    assign i_tready   = !((r_phase == nrpp_pkg::PH_LONHEMI) && w_lon_busy);

    assign o_tvalid = r_out_vld;
    assign o_tdata  = {{(nrpp_pkg::OUT_TDATA_W - nrpp_pkg::UTC_W - 2 * nrpp_pkg::COORD_W){1'b0}},
                       r_out_lon, r_out_lat, r_out_time};

endmodule

`default_nettype wire

>>> src/nrpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_position_parser_macros.svh"

module nrpp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_tvalid,
    input wire        i_tready,
    input wire [7:0]  i_tdata,
    input wire        o_tvalid,
    input wire        o_tready,
    input wire [nrpp_pkg::OUT_TDATA_W-1:0] o_tdata
);

    logic w_in_acc;
    logic w_in_seen;

    assign w_in_acc  = i_tvalid && i_tready;
    assign w_in_seen = (i_tdata != 8'h00) || 1'b1;

    // A stalled result keeps its value
    `NRPP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_tvalid && !o_tready, $stable(o_tdata))

    // Reset empties the output register
    `NRPP_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_tvalid)

    // A fresh result lines up with an earlier accepted input character
    `NRPP_ASSERT_IMP(a_out_latency, i_clk, i_rst_n, $rose(o_tvalid), $past(w_in_acc && w_in_seen, 6))

    // Time stays below 1000000000 ms and padding stays clear
    `NRPP_ASSERT_IMP(a_time_range, i_clk, i_rst_n, o_tvalid, o_tdata[29:0] < 30'd1000000000)
    `NRPP_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_tvalid, o_tdata[nrpp_pkg::OUT_TDATA_W-1:100] == '0)

endmodule

bind nmea_rmc_position_parser nrpp_checker u_nrpp_checker (.*);

`default_nettype wire

>>> test/tb_nmea_rmc_position_parser.sv
`timescale 1ns / 1ps

module tb_nmea_rmc_position_parser;
    import nrpp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TARGET_CHARS = 2000;
    localparam int TARGET_FIXES = 48;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_PRINTS   = 100;
    localparam int N_ROWS       = 15;

    // One position fix, packed in o_tdata order (utc lowest)
    typedef struct packed {
        t_coord lon;
        t_coord lat;
        t_utc   utc;
    } fix_t;

    // Directed sentence, with its fix typed in where it is obvious
    typedef struct {
        string  txt;
        bit     typed;
        t_utc   utc;
        t_coord lat;
        t_coord lon;
    } row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_tvalid;
    wire                    i_tready;
    logic [7:0]             i_tdata;    // [7:0] rx_byte
    wire                    o_tvalid;
    logic                   o_tready;
    wire  [OUT_TDATA_W-1:0] o_tdata;    // [29:0] utc, [64:30] lat, [99:65] lon

    nmea_rmc_position_parser DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .i_tready (i_tready),
        .i_tdata  (i_tdata),
        .o_tvalid (o_tvalid),
        .o_tready (o_tready),
        .o_tdata  (o_tdata)
    );

    // Predictor state
    t_phase    ph;
    t_acc_int  int_acc;
    t_acc_frac frac_acc;
    t_cnt      int_cnt;
    t_cnt      frac_cnt;
    logic      pt_seen;
    t_utc      utc_hold;
    logic [33:0] lat_raw;
    t_coord    lat_e7;
    string     head_txt = "GPRMC";

    fix_t      fixes_due[$];
    t_byte     line_q[$];
    row_t      rows[N_ROWS];
    bit        row_typed;
    fix_t      row_fix;
    int        errors;
    int        chars_sent;
    int        fixes_made;
    int        cycles;
    int        in_left, out_left;
    bit        in_busy, out_busy;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL nmea_rmc_position_parser");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic longint unsigned dec_scale(input int n);
        longint unsigned v;
        v = 1;
        repeat (n) v = v * 10;
        return v;
    endfunction

    // Idle cycles before the next item; busy and quiet stretches follow in random order
    function automatic int draw_gap(inout int left, inout bit busy);
        if (left <= 0) begin
            left = $urandom_range(4, 20);
            busy = ($urandom_range(0, 2) != 0);
        end
        left--;
        return busy ? $urandom_range(0, 11) : 0;
    endfunction

    task automatic clear_num();
        int_acc  = '0;
        frac_acc = '0;
        int_cnt  = '0;
        frac_cnt = '0;
        pt_seen  = 1'b0;
    endtask

    // One character of a number field
    task automatic num_char(input t_byte b, input int max_i, input int max_f,
                            output t_num_res r);
        r = NUM_MORE;
        if (b >= CH_0 && b <= CH_9) begin
            if (!pt_seen) begin
                if (int_cnt >= max_i) begin
                    r = NUM_BAD;
                end else begin
                    int_acc = int_acc * 10 + (b - CH_0);
                    int_cnt++;
                end
            end else begin
                // digits past the kept count are dropped
                if (frac_cnt < max_f) frac_acc = frac_acc * 10 + (b - CH_0);
                if (frac_cnt < FRAC_CNT_MAX) frac_cnt++;
            end
        end else if (b == CH_POINT) begin
            if (pt_seen) r = NUM_BAD;
            else pt_seen = 1'b1;
        end else if (b == CH_COMMA) begin
            r = (int_cnt == 0 && frac_cnt == 0) ? NUM_BAD : NUM_END;
        end else begin
            r = NUM_BAD;
        end
    endtask

    // Coordinate as integer scaled by 10^COORD_FRAC_DIGITS
    function automatic logic [33:0] coord_scaled();
        int k;
        k = (frac_cnt < COORD_FRAC_DIGITS) ? int'(frac_cnt) : COORD_FRAC_DIGITS;
        return 34'(int_acc * dec_scale(COORD_FRAC_DIGITS)
                   + frac_acc * dec_scale(COORD_FRAC_DIGITS - k));
    endfunction

    // ddmm.mmm to degrees * 1e7, truncated, negated for S or W
    function automatic t_coord to_e7(input longint unsigned raw, input t_byte hemi);
        longint unsigned unit, deg, minu, e7;
        unit = dec_scale(COORD_FRAC_DIGITS);
        deg  = raw / (100 * unit);
        minu = raw - deg * 100 * unit;
        e7   = deg * 64'd10000000 + (minu * 64'd10000000) / (60 * unit);
        if (hemi == CH_S || hemi == CH_W) e7 = -e7;
        return t_coord'(e7);
    endfunction

    // Advance the sentence parser by one received character
    task automatic take_char(input t_byte b, output bit done, output fix_t f);
        t_num_res r;
        bit       bad;
        int       k;
        done = 1'b0;
        bad  = 1'b0;
        f    = '0;
        case (ph)
            PH_HUNT, PH_P, PH_R, PH_M, PH_C: begin
                if (b == head_txt[int'(ph)]) ph = ph.next();
                else bad = 1'b1;
            end
            PH_COMMA0, PH_COMMA1, PH_COMMA2: begin
                if (b == CH_COMMA) begin
                    clear_num();
                    ph = ph.next();
                end else begin
                    bad = 1'b1;
                end
            end
            PH_TIME: begin
                num_char(b, TIME_INT_DIGITS, TIME_FRAC_DIGITS, r);
                if (r == NUM_BAD) begin
                    bad = 1'b1;
                end else if (r == NUM_END) begin
                    k = (frac_cnt < TIME_FRAC_DIGITS) ? int'(frac_cnt) : TIME_FRAC_DIGITS;
                    utc_hold = t_utc'(int_acc * 64'd1000 + frac_acc * dec_scale(3 - k));
                    ph = PH_A;
                end
            end
            PH_A: begin
                if (b == CH_A) ph = PH_COMMA1;
                else bad = 1'b1;
            end
            PH_LAT: begin
                num_char(b, COORD_INT_DIGITS, COORD_FRAC_DIGITS, r);
                if (r == NUM_BAD) begin
                    bad = 1'b1;
                end else if (r == NUM_END) begin
                    lat_raw = coord_scaled();
                    ph = PH_LATHEMI;
                end
            end
            PH_LATHEMI: begin
                lat_e7 = to_e7(lat_raw, b);
                ph = PH_COMMA2;
            end
            PH_LON: begin
                num_char(b, COORD_INT_DIGITS, COORD_FRAC_DIGITS, r);
                if (r == NUM_BAD) bad = 1'b1;
                else if (r == NUM_END) ph = PH_LONHEMI;
            end
            PH_LONHEMI: begin
                f.utc = utc_hold;
                f.lat = lat_e7;
                f.lon = to_e7(coord_scaled(), b);
                done  = 1'b1;
                ph    = PH_HUNT;
            end
            default: bad = 1'b1;
        endcase
        // a stray 'G' may open the next sentence
        if (bad) ph = (b == CH_G) ? PH_P : PH_HUNT;
    endtask

    // Check results, then predict from accepted characters
    always @(posedge i_clk) begin : scoreboard
        fix_t want, made;
        bit   done;
        if (i_rst_n) begin
            if (o_tvalid && o_tready) begin
                if (fixes_due.size() == 0) begin
                    flag_error("result with no sentence pending");
                end else begin
                    want = fixes_due.pop_front();
                    if (o_tdata[UTC_W-1:0] !== want.utc)
                        flag_error($sformatf("utc_time_ms %0d, want %0d",
                                             o_tdata[UTC_W-1:0], want.utc));
                    if (o_tdata[UTC_W +: COORD_W] !== want.lat)
                        flag_error($sformatf("latitude_e7 %0d, want %0d",
                                             $signed(o_tdata[UTC_W +: COORD_W]),
                                             $signed(want.lat)));
                    if (o_tdata[UTC_W+COORD_W +: COORD_W] !== want.lon)
                        flag_error($sformatf("longitude_e7 %0d, want %0d",
                                             $signed(o_tdata[UTC_W+COORD_W +: COORD_W]),
                                             $signed(want.lon)));
                end
            end
            if (i_tvalid && i_tready) begin
                take_char(i_tdata, done, made);
                if (done) begin
                    fixes_due.push_back(row_typed ? row_fix : made);
                    fixes_made++;
                end
            end
        end
    end

    // Result side back-pressure
    initial begin : sink
        int gap;
        o_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = draw_gap(out_left, out_busy);
            if (gap > 0) begin
                o_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            o_tready <= 1'b1;
            do @(posedge i_clk); while (!o_tvalid);
        end
    end

    // Present one character and hold it until taken
    task automatic send_char(input t_byte b);
        int gap;
        gap = draw_gap(in_left, in_busy);
        if (gap > 0) begin
            i_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= b;
        do @(posedge i_clk); while (!i_tready);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_text(input string s);
        foreach (s[i]) line_q.push_back(t_byte'(s[i]));
    endtask

    // Random number field, mostly valid, now and then one digit too many
    task automatic put_number(input int max_i);
        int ni, nf;
        bit pt, hi;
        ni = $urandom_range(0, max_i);
        if ($urandom_range(0, 19) == 0) ni = max_i + 1;
        pt = $urandom_range(0, 1);
        nf = pt ? $urandom_range(0, 8) : 0;
        if (ni == 0 && nf == 0) ni = 1;
        hi = ($urandom_range(0, 3) == 0);
        repeat (ni) line_q.push_back(hi ? CH_9 : t_byte'(CH_0 + $urandom_range(0, 9)));
        if (pt) line_q.push_back(CH_POINT);
        repeat (nf) line_q.push_back(hi ? CH_9 : t_byte'(CH_0 + $urandom_range(0, 9)));
    endtask

    task automatic put_hemi();
        case ($urandom_range(0, 5))
            0: line_q.push_back(t_byte'("N"));
            1: line_q.push_back(CH_S);
            2: line_q.push_back(t_byte'("E"));
            3: line_q.push_back(CH_W);
            default: line_q.push_back(t_byte'($urandom_range(0, 255)));
        endcase
    endtask

    // Noise, then a sentence with random content; some get damaged
    task automatic build_sentence();
        int pos;
        repeat ($urandom_range(0, 4)) line_q.push_back(t_byte'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) put_text("GPR");
        put_text("GPRMC,");
        put_number(TIME_INT_DIGITS);
        put_text(",A,");
        put_number(COORD_INT_DIGITS);
        line_q.push_back(CH_COMMA);
        put_hemi();
        line_q.push_back(CH_COMMA);
        put_number(COORD_INT_DIGITS);
        line_q.push_back(CH_COMMA);
        put_hemi();
        case ($urandom_range(0, 9))
            0: begin
                pos = $urandom_range(0, line_q.size() - 1);
                line_q[pos] = t_byte'($urandom_range(0, 255));
            end
            1: begin
                // cut the tail, leaving the parser part way through
                pos = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > pos) void'(line_q.pop_back());
            end
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int r, k;
        i_rst_n   = 1'b0;
        i_tvalid  = 1'b0;
        i_tdata   = '0;
        row_typed = 1'b0;
        row_fix   = '0;
        ph        = PH_HUNT;
        clear_num();
        utc_hold  = '0;
        lat_raw   = '0;
        lat_e7    = '0;

        rows = '{
            // all zero
            '{"GPRMC,000000,A,0,N,0,E", 1'b1, 30'd0, 35'd0, 35'd0},
            // largest values, both negated
            '{"GPRMC,999999.999,A,99999.99999,S,99999.99999,W", 1'b1,
              30'd999999999, -35'sd10006666665, -35'sd10006666665},
            // fraction-only numbers
            '{"GPRMC,.5,A,.5,N,.5,N", 1'b1, 30'd500, 35'd83333, 35'd83333},
            '{"GPRMC,123519,A,4807.038,N,01131.000,E", 1'b0, '0, '0, '0},
            // broken header restarted by its own G; letters swapped over
            '{"GPRMGPRMC,092750.000,A,5321.6802,W,00630.3372,S", 1'b0, '0, '0, '0},
            // second point
            '{"GPRMC,1.2.3,A,1,N,1,E", 1'b0, '0, '0, '0},
            // empty time
            '{"GPRMC,,A,1,N,1,E", 1'b0, '0, '0, '0},
            // seven time digits
            '{"GPRMC,1234567,A,1,N,1,E", 1'b0, '0, '0, '0},
            // surplus fraction digits, odd hemisphere bytes
            '{"GPRMC,235959.1234567,A,8959.9999999,x,17959.99999999,~", 1'b0,
              '0, '0, '0},
            // six coordinate digits
            '{"GPRMC,1,A,1,N,123456,E", 1'b0, '0, '0, '0},
            // void status
            '{"GPRMC,1,V,1,N,1,E", 1'b0, '0, '0, '0},
            // stray letter in a number
            '{"GPRMC,1,A,1a,N,1,E", 1'b0, '0, '0, '0},
            // trailing point
            '{"GPRMC,1,A,1.,N,1,E", 1'b0, '0, '0, '0},
            // missing comma after hemisphere
            '{"GPRMC,1,A,1,NN,1,E", 1'b0, '0, '0, '0},
            // point with no digits
            '{"GPRMC,1,A,.,N", 1'b0, '0, '0, '0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sentences
        for (r = 0; r < N_ROWS; r++) begin
            row_typed   = rows[r].typed;
            row_fix.utc = rows[r].utc;
            row_fix.lat = rows[r].lat;
            row_fix.lon = rows[r].lon;
            for (k = 0; k < rows[r].txt.len(); k++)
                send_char(t_byte'(rows[r].txt[k]));
            row_typed = 1'b0;
        end

        // Random sentences and noise
        while (chars_sent < TARGET_CHARS || fixes_made < TARGET_FIXES) begin
            line_q.delete();
            build_sentence();
            foreach (line_q[j]) send_char(line_q[j]);
        end
        i_tvalid <= 1'b0;

        // Drain, then allow for pipeline latency
        while (fixes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS nmea_rmc_position_parser");
        end else begin
            $display("FAIL nmea_rmc_position_parser");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/nrpp_pkg.sv
src/nmea_rmc_position_parser.sv
src/nrpp_checker.sv
test/tb_nmea_rmc_position_parser.sv
